@@ hdl/fec_pkg.sv @@
// Shared types and constants of the feedback echo comb filter.
`default_nettype none

package fec_pkg;

  localparam int unsigned SampleFieldW = 32;
  localparam int unsigned CfgW         = 16;
  localparam int unsigned GainFracBits = 16;

  localparam logic [CfgW-1:0] DelayReset = 16'd48000;
  localparam logic [CfgW-1:0] GainReset  = 16'd32768;

  typedef enum logic [0:0] {
    CFG_DELAY_SAMPLES = 1'b0,
    CFG_ECHO_GAIN     = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [SampleFieldW-1:0] in_sample;
    logic                    in_last;
  } fec_in_t;

  typedef struct packed {
    logic [SampleFieldW-1:0] out_sample;
    logic                    out_last;
    logic                    out_saturated;
  } fec_out_t;

  typedef struct packed {
    logic pass_through;
    logic zero_delay;
    logic forward;
  } mac_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/fec_ram.sv @@
// Delay line memory of past output samples, one write port and one registered read port.
`default_nettype none

module fec_ram #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/fec_mac.sv @@
// Echo multiply-add with saturation and the pass-through and zero-delay selections.
`default_nettype none

module fec_mac
  import fec_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  wire mac_ctrl_t              ctrl_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  input  wire logic [SAMPLE_BITS-1:0] mem_data_i,
  input  wire logic [SAMPLE_BITS-1:0] fwd_data_i,
  input  wire logic [CfgW-1:0]        gain_i,
  output logic      [SAMPLE_BITS-1:0] result_o,
  output logic                        saturated_o
);

  logic [SAMPLE_BITS-1:0]              delayed;
  logic [SAMPLE_BITS+GainFracBits-1:0] product;
  logic [SAMPLE_BITS:0]                sum;

  always_comb begin
    priority if (ctrl_i.zero_delay) begin
      delayed = sample_i;
    end else if (ctrl_i.forward) begin
      delayed = fwd_data_i;
    end else begin
      delayed = mem_data_i;
    end
    product = (SAMPLE_BITS+GainFracBits)'(delayed) * (SAMPLE_BITS+GainFracBits)'(gain_i);
    sum     = {1'b0, sample_i} + {1'b0, product[SAMPLE_BITS+GainFracBits-1:GainFracBits]};
    if (ctrl_i.pass_through) begin
      result_o    = sample_i;
      saturated_o = 1'b0;
    end else if (sum[SAMPLE_BITS]) begin
      result_o    = '1;
      saturated_o = 1'b1;
    end else begin
      result_o    = sum[SAMPLE_BITS-1:0];
      saturated_o = 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ hdl/feedback_echo_comb.sv @@
// Top level of the feedback echo comb filter.
//
// The filter takes one sample transfer per clock cycle while the output side is ready and
// returns one result per sample via the sample and output registers. The sustained rate of
// one sample per cycle is set by the delay line RAM, which is read once per sample at
// input transfer and written once per sample as its result leaves the multiply-add stage;
// the previous result is forwarded from the output register so a delay of one sample
// runs at full rate. Configuration writes must happen while no samples are in flight.
// The delay is clamped to MAX_DELAY - 1. The delay line needs no clearing after reset.
`default_nettype none

module feedback_echo_comb
  import fec_pkg::*;
#(
  parameter int unsigned MAX_DELAY   = 65536,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire fec_in_t         in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output fec_out_t             out_data_o,
  input  wire logic            cfg_we_i,
  input  wire cfg_idx_e        cfg_idx_i,
  input  wire logic [CfgW-1:0] cfg_data_i
);

  localparam int unsigned AW     = $clog2(MAX_DELAY);
  localparam int unsigned MaxD   = MAX_DELAY - 1;
  localparam logic [AW:0] Depth  = (AW+1)'(MAX_DELAY);
  localparam logic [AW-1:0] LastIdx = AW'(MaxD);

  logic [CfgW-1:0] delay_q, gain_q;
  logic [AW-1:0]   wr_idx_q, wr_idx_d;
  logic [AW:0]     fill_q, fill_d;

  logic                   b_valid_q;
  logic [SAMPLE_BITS-1:0] b_sample_q;
  logic                   b_last_q;
  mac_ctrl_t              b_ctrl_q, b_ctrl_d;
  logic [AW-1:0]          b_waddr_q;

  logic                   out_valid_q;
  fec_out_t               out_data_q;

  logic                   in_xfer, b_adv;
  logic [AW-1:0]          dly, rd_addr;
  logic [SAMPLE_BITS-1:0] mem_rdata, mac_y;
  logic                   mac_sat;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DelayReset;
      gain_q  <= GainReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DELAY_SAMPLES: delay_q <= cfg_data_i;
        CFG_ECHO_GAIN:     gain_q  <= cfg_data_i;
        default:           ;
      endcase
    end
  end

  assign b_adv      = b_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !b_valid_q || b_adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    if (32'(delay_q) > MaxD) begin
      dly = LastIdx;
    end else begin
      dly = AW'(delay_q);
    end
    if (wr_idx_q >= dly) begin
      rd_addr = wr_idx_q - dly;
    end else begin
      rd_addr = AW'({1'b0, wr_idx_q} + Depth - {1'b0, dly});
    end
    b_ctrl_d.pass_through = fill_q < {1'b0, dly};
    b_ctrl_d.zero_delay   = (dly == '0);
    b_ctrl_d.forward      = b_adv && (rd_addr == b_waddr_q);
    if (wr_idx_q == LastIdx) begin
      wr_idx_d = '0;
    end else begin
      wr_idx_d = wr_idx_q + 1'b1;
    end
    if (fill_q < Depth) begin
      fill_d = fill_q + 1'b1;
    end else begin
      fill_d = fill_q;
    end
    if (in_data_i.in_last) begin
      wr_idx_d = '0;
      fill_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q    <= '0;
      fill_q      <= '0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        wr_idx_q <= wr_idx_d;
        fill_q   <= fill_d;
      end
      if (in_xfer) begin
        b_valid_q <= 1'b1;
      end else if (b_adv) begin
        b_valid_q <= 1'b0;
      end
      if (b_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      b_sample_q <= in_data_i.in_sample[SAMPLE_BITS-1:0];
      b_last_q   <= in_data_i.in_last;
      b_ctrl_q   <= b_ctrl_d;
      b_waddr_q  <= wr_idx_q;
    end
    if (b_adv) begin
      out_data_q.out_sample    <= SampleFieldW'(mac_y);
      out_data_q.out_last      <= b_last_q;
      out_data_q.out_saturated <= mac_sat;
    end
  end

  fec_ram #(
    .DEPTH (MAX_DELAY),
    .WIDTH (SAMPLE_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (b_adv),
    .waddr_i (b_waddr_q),
    .wdata_i (mac_y),
    .re_i    (in_xfer),
    .raddr_i (rd_addr),
    .rdata_o (mem_rdata)
  );

  fec_mac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .ctrl_i      (b_ctrl_q),
    .sample_i    (b_sample_q),
    .mem_data_i  (mem_rdata),
    .fwd_data_i  (out_data_q.out_sample[SAMPLE_BITS-1:0]),
    .gain_i      (gain_q),
    .result_o    (mac_y),
    .saturated_o (mac_sat)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

@@ verif/fec_checker.sv @@
// Checker that predicts and compares every result of the feedback echo comb filter.
`timescale 1ns / 100ps

module fec_checker
  import fec_pkg::*;
#(
  parameter int unsigned MAX_DELAY   = 65536,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  fec_in_t         in_data_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  fec_out_t        out_data_i,
  input  logic            cfg_we_i,
  input  cfg_idx_e        cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  output int unsigned     err_count_o,
  output int unsigned     pending_o
);

  logic [CfgW-1:0]        delay_q;
  logic [CfgW-1:0]        gain_q;
  logic [SAMPLE_BITS-1:0] echo_line [MAX_DELAY];
  int unsigned            wr_ptr;
  int unsigned            fill_cnt;
  fec_out_t               expected_q [$];
  fec_out_t               want;

  function automatic fec_out_t predict_echo(fec_in_t item);
    logic [63:0] sample_max;
    logic [63:0] x;
    logic [63:0] delayed;
    logic [63:0] sum;
    int unsigned d;
    int unsigned rd;
    fec_out_t    res;
    sample_max = (64'd1 << SAMPLE_BITS) - 64'd1;
    x = {32'b0, item.in_sample} & sample_max;
    d = delay_q;
    if (d > MAX_DELAY - 1) d = MAX_DELAY - 1;
    sum = x;
    res.out_saturated = 1'b0;
    if (fill_cnt >= d) begin
      if (d == 0) begin
        delayed = x;
      end else begin
        rd = (wr_ptr >= d) ? wr_ptr - d : wr_ptr + MAX_DELAY - d;
        delayed = 64'(echo_line[rd]);
      end
      sum = x + ((delayed * 64'(gain_q)) >> GainFracBits);
      if (sum > sample_max) begin
        sum = sample_max;
        res.out_saturated = 1'b1;
      end
    end
    echo_line[wr_ptr] = sum[SAMPLE_BITS-1:0];
    wr_ptr = wr_ptr + 1;
    if (wr_ptr >= MAX_DELAY) wr_ptr = 0;
    if (fill_cnt < MAX_DELAY) fill_cnt = fill_cnt + 1;
    if (item.in_last) begin
      wr_ptr   = 0;
      fill_cnt = 0;
    end
    res.out_sample = sum[SampleFieldW-1:0];
    res.out_last   = item.in_last;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q     = DelayReset;
      gain_q      = GainReset;
      wr_ptr      = 0;
      fill_cnt    = 0;
      err_count_o = 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DELAY_SAMPLES: delay_q = cfg_data_i;
          CFG_ECHO_GAIN:     gain_q  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(predict_echo(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transfer: out_sample %h", out_data_i.out_sample);
          err_count_o = err_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (out_data_i.out_sample !== want.out_sample) begin
            $error("out_sample mismatch: expected %h, actual %h",
                   want.out_sample, out_data_i.out_sample);
            err_count_o = err_count_o + 1;
          end
          if (out_data_i.out_last !== want.out_last) begin
            $error("out_last mismatch: expected %b, actual %b",
                   want.out_last, out_data_i.out_last);
            err_count_o = err_count_o + 1;
          end
          if (out_data_i.out_saturated !== want.out_saturated) begin
            $error("out_saturated mismatch: expected %b, actual %b",
                   want.out_saturated, out_data_i.out_saturated);
            err_count_o = err_count_o + 1;
          end
        end
      end
    end
    pending_o = expected_q.size();
  end

endmodule

@@ verif/tb.sv @@
// Testbench top of the feedback echo comb filter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;
  import fec_pkg::*;

  localparam int unsigned MaxDelay   = 65536;
  localparam int unsigned SampleBits = 32;
  localparam int unsigned CycleLimit = 3000000;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  fec_in_t         in_data   = '0;
  logic            out_ready = 1'b0;
  logic            cfg_we    = 1'b0;
  cfg_idx_e        cfg_idx   = CFG_DELAY_SAMPLES;
  logic [CfgW-1:0] cfg_data  = '0;
  logic            in_ready;
  logic            out_valid;
  fec_out_t        out_data;
  int unsigned     err_count;
  int unsigned     pending;
  int unsigned     cycle_cnt = 0;
  logic            idle_en   = 1'b1;

  always #5 clk = ~clk;

  feedback_echo_comb #(
    .MAX_DELAY   (MaxDelay),
    .SAMPLE_BITS (SampleBits)
  ) u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  fec_checker #(
    .MAX_DELAY   (MaxDelay),
    .SAMPLE_BITS (SampleBits)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (idle_en && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(0, 30)) @(negedge clk);
    end
  end

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $urandom_range(0, 65535);
      2:       return 32'hFFFF_FFFF - $urandom_range(0, 255);
      default: return $urandom_range(0, 32'h7FFF_FFFF);
    endcase
  endfunction

  task automatic send_sample(input logic [31:0] sample, input logic last);
    @(negedge clk);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_data.in_sample <= sample;
    in_data.in_last   <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic flush_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic set_echo(input logic [CfgW-1:0] delay, input logic [CfgW-1:0] gain);
    flush_results();
    write_reg(CFG_DELAY_SAMPLES, delay);
    write_reg(CFG_ECHO_GAIN, gain);
  endtask

  task automatic stream_files(input int unsigned delay, input int unsigned n_items);
    int unsigned sent;
    int unsigned file_len;
    sent = 0;
    while (sent < n_items) begin
      file_len = $urandom_range(1, 3 * delay + 8);
      for (int unsigned i = 0; i < file_len && sent < n_items; i++) begin
        send_sample(pick_sample(), i == file_len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned delay;
    logic [CfgW-1:0] gain;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings keep every sample in pass-through.
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b1);

    set_echo(16'd1, 16'hFFFF);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h0000_0001, 1'b0);
    send_sample(32'h0001_0000, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h8000_0000, 1'b1);

    set_echo(16'd0, GainReset);
    send_sample(32'd100, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'hAAAA_AAAA, 1'b0);
    send_sample(32'h0000_0000, 1'b1);

    set_echo(16'd3, 16'd0);
    for (int i = 0; i < 6; i++) send_sample(pick_sample(), i == 5);

    for (int p = 0; p < 8; p++) begin
      case ($urandom_range(0, 5))
        0:       delay = 0;
        1:       delay = 1;
        2, 3:    delay = $urandom_range(2, 16);
        4:       delay = $urandom_range(17, 200);
        default: delay = 2;
      endcase
      case ($urandom_range(0, 3))
        0:       gain = 16'd0;
        1:       gain = 16'hFFFF;
        2:       gain = 16'($urandom_range(0, 65535));
        default: gain = GainReset;
      endcase
      set_echo(delay[CfgW-1:0], gain);
      if (p >= 6) idle_en = 1'b0;
      stream_files(delay, 100);
    end

    // The longest delay keeps a short file in pass-through.
    set_echo(16'hFFFF, 16'($urandom_range(0, 65535)));
    for (int i = 0; i < 30; i++) send_sample(pick_sample(), i == 29);
    for (int i = 0; i < 10; i++) send_sample(pick_sample(), i == 9);

    flush_results();
    repeat (8) @(negedge clk);
    if (err_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/fec_pkg.sv
hdl/fec_ram.sv
hdl/fec_mac.sv
hdl/feedback_echo_comb.sv
verif/fec_checker.sv
verif/tb.sv
